/* hw/rtl/bba_pkg.sv */
// shared constants, types and functions of the bitmap block allocator
package bba_pkg;

   // pool size and field widths
   localparam int NUM_BLOCKS = 8 * 1024;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 13;
   localparam int COUNT_W    = 14;

   // bitmap word organisation
   localparam int WORD_BITS   = 32;
   localparam int BIT_SEL_W   = $clog2(WORD_BITS);
   localparam int NUM_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [WORD_ADDR_W-1:0] waddr_type;

   // access bundle from the control logic to the bitmap memory
   typedef struct packed {
      logic      rd_en;
      waddr_type rd_addr;
      logic      wr_en;
      waddr_type wr_addr;
      word_type  wr_data;
   } mem_req_type;

   // contents of a bitmap word before its first write: block 0 reserved,
   // blocks past the end of the pool permanently used
   function automatic word_type row_reset(waddr_type row);
      word_type w;
      w = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if ((int'(row) * WORD_BITS + b) >= NUM_BLOCKS) begin
            w[b] = 1'b1;
         end
      end
      if (row == '0) begin
         w[0] = 1'b1;
      end
      return w;
   endfunction

endpackage

/* hw/rtl/bba_channels_if.sv */
// request and response channel interfaces of the bitmap block allocator
interface bba_req_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::OP_W-1:0]      operation;
   logic [bba_pkg::INDEX_W-1:0]   block_index;
   logic [bba_pkg::COUNT_W-1:0]   request_count;

   modport source (output valid, operation, block_index, request_count, input ready);
   modport sink   (input valid, operation, block_index, request_count, output ready);
endinterface

interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic [bba_pkg::INDEX_W-1:0]   granted_index;
   logic [bba_pkg::COUNT_W-1:0]   free_blocks;

   modport source (output valid, status, granted_index, free_blocks, input ready);
   modport sink   (input valid, status, granted_index, free_blocks, output ready);
endinterface

/* hw/rtl/bba_bitmap.sv */
// used/free bitmap memory, one read and one write port, registered read
module bba_bitmap (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::mem_req_type  mem_req,
   output bba_pkg::word_type     rd_word
);

   bba_pkg::word_type             bitmap_mem [bba_pkg::NUM_WORDS];
   logic [bba_pkg::NUM_WORDS-1:0] valid_ff;
   bba_pkg::word_type             rd_data_ff;
   bba_pkg::waddr_type            rd_row_ff;
   logic                          rd_valid_ff;

   // storage array and read data
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         bitmap_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= bitmap_mem[mem_req.rd_addr];
         rd_row_ff  <= mem_req.rd_addr;
      end
   end

   // per-word written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // unwritten words read as their reset contents
   assign rd_word = rd_valid_ff ? rd_data_ff : bba_pkg::row_reset(rd_row_ff);

endmodule

/* hw/rtl/bitmap_block_allocator.sv */
// First-fit block allocator over a pool of 8192 blocks kept as a bitmap of
// 32-bit words in a single-port-read memory, with a low-water hint below which
// every block is used. One request is handled at a time and the response sits
// in an output register, so a new request is taken while the last response
// waits. An allocate reads the bitmap one word per cycle, from the word holding
// the hint up to the first word with a free block or the last word (1 to 256
// words; none when the hint is past the pool), then responds. A free reads the
// word, then modifies and writes it back, then responds. A query, an allocate
// with the hint past the pool and a request rejected on its opcode or index
// respond with no bitmap access, since the free count answers the query. The
// bitmap needs no clearing pass after reset: a request can be taken at once.
module bitmap_block_allocator (
   input logic        clock,
   input logic        reset,
   bba_req_if.sink    req_bus,
   bba_rsp_if.source  rsp_bus
);

   localparam int IDX_W = bba_pkg::INDEX_W;
   localparam int CNT_W = bba_pkg::COUNT_W;
   localparam int WA_W  = bba_pkg::WORD_ADDR_W;
   localparam int BS_W  = bba_pkg::BIT_SEL_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_CHECK,
      S_RESULT
   } state_type;

   // lowest clear bit of a bitmap word
   function automatic logic [BS_W-1:0] lowest_clear(bba_pkg::word_type w);
      logic [BS_W-1:0] r;
      r = '0;
      for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r = BS_W'(i);
         end
      end
      return r;
   endfunction

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                hint_ff, hint_in;
   logic [CNT_W-1:0]                free_total_ff, free_total_in;
   bba_pkg::waddr_type              ptr_ff, ptr_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [bba_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [IDX_W-1:0]                res_granted_ff, res_granted_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]                rsp_granted_ff, rsp_granted_in;
   logic [CNT_W-1:0]                rsp_free_ff, rsp_free_in;

   bba_pkg::mem_req_type            mem_req;
   bba_pkg::word_type               rd_word;

   logic                            accept;
   logic                            out_free;
   bba_pkg::waddr_type              hint_word;
   logic [BS_W-1:0]                 hint_bit;
   bba_pkg::word_type               low_mask;
   bba_pkg::word_type               scan_word;
   logic                            scan_hit;
   logic [BS_W-1:0]                 hit_bit;
   logic                            last_word;
   bba_pkg::waddr_type              idx_word;
   logic [BS_W-1:0]                 idx_bit;
   logic                            idx_ok;
   logic                            query_ok;

   bba_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   // handshake
   assign req_bus.ready         = (state_ff == S_IDLE);
   assign accept                = req_bus.valid && req_bus.ready;
   assign out_free              = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_index = rsp_granted_ff;
   assign rsp_bus.free_blocks   = rsp_free_ff;

   // search of the current word, blocks below the hint masked off
   assign hint_word = WA_W'(hint_ff >> BS_W);
   assign hint_bit  = hint_ff[BS_W-1:0];
   assign low_mask  = (bba_pkg::word_type'(1) << hint_bit) - bba_pkg::word_type'(1);
   assign scan_word = rd_word | ((ptr_ff == hint_word) ? low_mask : '0);
   assign scan_hit  = ~&scan_word;
   assign hit_bit   = lowest_clear(scan_word);
   assign last_word = (ptr_ff == WA_W'(bba_pkg::NUM_WORDS - 1));

   // free and query checks
   assign idx_word = WA_W'(idx_ff >> BS_W);
   assign idx_bit  = idx_ff[BS_W-1:0];
   assign idx_ok   = (req_bus.block_index != '0)
                  && (CNT_W'(req_bus.block_index) < CNT_W'(bba_pkg::NUM_BLOCKS));
   assign query_ok = (req_bus.request_count == '0)
                  || (free_total_ff >= req_bus.request_count);

   // next state and memory accesses
   always_comb begin
      state_in       = state_ff;
      hint_in        = hint_ff;
      free_total_in  = free_total_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      mem_req        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_granted_in = '0;
               idx_in         = req_bus.block_index;
               case (req_bus.operation)
                  bba_pkg::OP_ALLOC: begin
                     if (hint_ff >= CNT_W'(bba_pkg::NUM_BLOCKS)) begin
                        res_status_in = bba_pkg::ST_SHORT;
                        state_in      = S_RESULT;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = hint_word;
                        ptr_in          = hint_word;
                        state_in        = S_ALLOC_SCAN;
                     end
                  end
                  bba_pkg::OP_FREE: begin
                     if (idx_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = WA_W'(req_bus.block_index >> BS_W);
                        state_in        = S_FREE_CHECK;
                     end else begin
                        res_status_in = bba_pkg::ST_INVALID;
                        state_in      = S_RESULT;
                     end
                  end
                  bba_pkg::OP_QUERY: begin
                     res_status_in = query_ok ? bba_pkg::ST_OK : bba_pkg::ST_SHORT;
                     state_in      = S_RESULT;
                  end
                  default: begin
                     res_status_in = bba_pkg::ST_INVALID;
                     state_in      = S_RESULT;
                  end
               endcase
            end
         end
         S_ALLOC_SCAN: begin
            if (scan_hit) begin
               // claim the block and move the hint past it
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ptr_ff;
               mem_req.wr_data = rd_word | (bba_pkg::word_type'(1) << hit_bit);
               hint_in         = CNT_W'({ptr_ff, hit_bit}) + CNT_W'(1);
               free_total_in   = free_total_ff - CNT_W'(1);
               res_status_in   = bba_pkg::ST_OK;
               res_granted_in  = IDX_W'({ptr_ff, hit_bit});
               state_in        = S_RESULT;
            end else if (last_word) begin
               res_status_in = bba_pkg::ST_SHORT;
               state_in      = S_RESULT;
            end else begin
               // next word of the bitmap
               ptr_in          = ptr_ff + WA_W'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff + WA_W'(1);
            end
         end
         S_FREE_CHECK: begin
            if (rd_word[idx_bit]) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_word;
               mem_req.wr_data = rd_word & ~(bba_pkg::word_type'(1) << idx_bit);
               free_total_in   = free_total_ff + CNT_W'(1);
               if (CNT_W'(idx_ff) < hint_ff) begin
                  hint_in = CNT_W'(idx_ff);
               end
               res_status_in = bba_pkg::ST_OK;
            end else begin
               // block already free
               res_status_in = bba_pkg::ST_INVALID;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_free_in    = free_total_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hint_ff       <= CNT_W'(1);
         free_total_ff <= CNT_W'(bba_pkg::NUM_BLOCKS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hint_ff       <= hint_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ptr_ff         <= ptr_in;
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

endmodule

/* hw/rtl/bba_checker.sv */
// port-level assertions for the bitmap block allocator, bound to the top level
module bba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bba_pkg::INDEX_W-1:0]   rsp_granted_index,
   input logic [bba_pkg::COUNT_W-1:0]   rsp_free_blocks
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_index) && $stable(rsp_free_blocks))
      else $error("stalled response changed");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // no granted index without success
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bba_pkg::ST_OK |-> rsp_granted_index == '0)
      else $error("granted index set on a failed request");

   // reserved block keeps the free count below the pool size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_blocks <= bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS - 1))
      else $error("free count beyond pool size");

   // a granted block is no longer counted as free
   a_grant_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bba_pkg::ST_OK && rsp_granted_index != '0
         |-> rsp_free_blocks < bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS - 1))
      else $error("free count not reduced by allocation");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_granted_index (rsp_bus.granted_index),
   .rsp_free_blocks   (rsp_bus.free_blocks)
);

/* tb/sv/tb_top.sv */
// self-checking testbench of the bitmap block allocator with its own pool predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   // operation code that the allocator does not define
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // stall limit and the long receiver hold-off
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE      = 300;

   // which side idles while a request is in flight
   typedef enum logic [1:0] {
      PACE_SLOW_SINK,
      PACE_SLOW_SOURCE,
      PACE_STEADY
   } pace_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] cnt;
      pace_type           pace;
   } blk_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  granted;
      logic [COUNT_W-1:0]  free;
   } blk_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   bitmap_block_allocator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted pool state
   bit          used_bits [NUM_BLOCKS];
   int unsigned low_mark;
   int unsigned free_cnt;
   int          top_granted;

   // requests waiting to be driven and outcomes waiting to be seen
   blk_req_type request_q [$];
   blk_rsp_type outcome_q [$];

   blk_req_type seen_req;
   blk_rsp_type want_rsp;
   logic        req_taken = 1'b0;
   pace_type    cur_pace = PACE_SLOW_SINK;
   int          result_count = 0;
   int          mismatch_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          stall_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // first-fit allocation, free and query on the predicted pool
   function automatic blk_rsp_type predict_outcome(blk_req_type r);
      blk_rsp_type o;
      int unsigned seen;
      o.status  = ST_INVALID;
      o.granted = '0;
      seen      = 0;
      case (r.op)
         OP_ALLOC: begin
            o.status = ST_SHORT;
            for (int i = int'(low_mark); i < NUM_BLOCKS && o.status == ST_SHORT; i++) begin
               if (!used_bits[i]) begin
                  used_bits[i] = 1'b1;
                  low_mark     = i + 1;
                  free_cnt     = free_cnt - 1;
                  o.granted    = INDEX_W'(i);
                  o.status     = ST_OK;
                  if (i > top_granted) begin
                     top_granted = i;
                  end
               end
            end
         end
         OP_FREE: begin
            // reserved block, out of range and double free are all rejected
            if (r.idx != '0 && int'(r.idx) < NUM_BLOCKS && used_bits[r.idx]) begin
               used_bits[r.idx] = 1'b0;
               free_cnt         = free_cnt + 1;
               if (r.idx < low_mark) begin
                  low_mark = r.idx;
               end
               o.status = ST_OK;
            end
         end
         OP_QUERY: begin
            o.status = (r.cnt == '0) ? ST_OK : ST_SHORT;
            for (int i = int'(low_mark); i < NUM_BLOCKS && o.status == ST_SHORT; i++) begin
               if (!used_bits[i]) begin
                  seen++;
                  if (seen >= r.cnt) begin
                     o.status = ST_OK;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.free = COUNT_W'(free_cnt);
      return o;
   endfunction

   function automatic void queue_req(logic [OP_W-1:0] op, int unsigned idx, int unsigned cnt,
                                     pace_type pace);
      blk_req_type r;
      r.op   = op;
      r.idx  = INDEX_W'(idx);
      r.cnt  = COUNT_W'(cnt);
      r.pace = pace;
      request_q.push_back(r);
   endfunction

   // random request shaped by the current pool state
   function automatic blk_req_type random_request(pace_type pace, int alloc_pct);
      blk_req_type r;
      int          pick;
      int          cand;
      r.pace = pace;
      r.op   = OP_ALLOC;
      r.idx  = INDEX_W'($urandom);
      r.cnt  = COUNT_W'($urandom_range(NUM_BLOCKS));
      pick   = int'($urandom_range(99));
      if (pick < alloc_pct) begin
         r.op = OP_ALLOC;
      end else if (pick < alloc_pct + 30) begin
         // free of a block that is most likely held
         r.op = OP_FREE;
         cand = int'($urandom_range(top_granted, 1));
         for (int t = 0; t < 16 && !used_bits[cand]; t++) begin
            cand = int'($urandom_range(top_granted, 1));
         end
         r.idx = INDEX_W'(cand);
      end else if (pick < alloc_pct + 38) begin
         // reserved block or an arbitrary index
         r.op = OP_FREE;
         if ($urandom_range(3) == 0) begin
            r.idx = '0;
         end
      end else if (pick < 96) begin
         r.op = OP_QUERY;
         if ($urandom_range(2) != 0) begin
            cand = int'(free_cnt) + int'($urandom_range(6)) - 3;
            if (cand < 0) begin
               cand = 0;
            end else if (cand > NUM_BLOCKS) begin
               cand = NUM_BLOCKS;
            end
            r.cnt = COUNT_W'(cand);
         end
      end else begin
         r.op = OP_SPARE;
      end
      return r;
   endfunction

   task automatic feed_random(pace_type pace, int count, int alloc_pct);
      for (int n = 0; n < count; n++) begin
         while (request_q.size() >= 8) begin
            @(posedge clock);
         end
         request_q.push_back(random_request(pace, alloc_pct));
      end
   endtask

   task automatic wait_quiet();
      while (request_q.size() != 0 || req_bus.valid || outcome_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (request_q.size() != 0 &&
             $urandom_range(99) >= ((request_q[0].pace == PACE_SLOW_SINK)   ? 22 :
                                    (request_q[0].pace == PACE_SLOW_SOURCE) ? 63 : 0)) begin
            req_bus.operation     <= request_q[0].op;
            req_bus.block_index   <= request_q[0].idx;
            req_bus.request_count <= request_q[0].cnt;
            req_bus.valid         <= 1'b1;
            cur_pace              <= request_q[0].pace;
            request_q.delete(0);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the allocator up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && result_count >= HOLD_AT) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= ((cur_pace == PACE_SLOW_SINK)   ? 63 :
                                                  (cur_pace == PACE_SLOW_SOURCE) ? 22 : 0));
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count <= result_count + 1;
            if (outcome_q.size() == 0) begin
               $display("%0t unexpected response: none expected, actual status %0d index %0d",
                        $time, rsp_bus.status, rsp_bus.granted_index,
                        " free %0d", rsp_bus.free_blocks);
               mismatch_count++;
            end else begin
               want_rsp = outcome_q.pop_front();
               if (rsp_bus.status !== want_rsp.status ||
                   rsp_bus.granted_index !== want_rsp.granted ||
                   rsp_bus.free_blocks !== want_rsp.free) begin
                  $display("%0t mismatch: expected status %0d index %0d free %0d,",
                           $time, want_rsp.status, want_rsp.granted, want_rsp.free,
                           " actual status %0d index %0d free %0d",
                           rsp_bus.status, rsp_bus.granted_index, rsp_bus.free_blocks);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_req.op   = req_bus.operation;
            seen_req.idx  = req_bus.block_index;
            seen_req.cnt  = req_bus.request_count;
            seen_req.pace = cur_pace;
            outcome_q.push_back(predict_outcome(seen_req));
         end
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_ALLOC;
      req_bus.block_index   = '0;
      req_bus.request_count = '0;
      rsp_bus.ready         = 1'b0;

      // pool after reset: block 0 reserved
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         used_bits[i] = 1'b0;
      end
      used_bits[0] = 1'b1;
      low_mark     = 1;
      free_cnt     = NUM_BLOCKS - 1;
      top_granted  = 1;

      // queries at the extremes, rejected frees, spare opcode
      queue_req(OP_QUERY, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_QUERY, 0, NUM_BLOCKS - 1, PACE_SLOW_SINK);
      queue_req(OP_QUERY, NUM_BLOCKS - 1, NUM_BLOCKS, PACE_SLOW_SINK);
      queue_req(OP_FREE, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_FREE, 5, 0, PACE_SLOW_SINK);
      queue_req(OP_FREE, NUM_BLOCKS - 1, NUM_BLOCKS, PACE_SLOW_SINK);
      queue_req(OP_SPARE, NUM_BLOCKS - 1, NUM_BLOCKS, PACE_SLOW_SINK);
      // allocate, free behind the hint, double free, reallocate
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_FREE, 2, 0, PACE_SLOW_SINK);
      queue_req(OP_FREE, 2, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_QUERY, 0, NUM_BLOCKS - 5, PACE_SLOW_SINK);
      queue_req(OP_QUERY, 0, NUM_BLOCKS - 4, PACE_SLOW_SINK);
      queue_req(OP_FREE, 1, 0, PACE_SLOW_SINK);
      queue_req(OP_FREE, 4, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SINK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // mostly empty pool
      feed_random(PACE_SLOW_SINK, 900, 50);

      // allocations, small queries and frees of the top block
      wait_quiet();
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SOURCE);
      queue_req(OP_ALLOC, NUM_BLOCKS - 1, NUM_BLOCKS, PACE_SLOW_SOURCE);
      queue_req(OP_QUERY, 0, 1, PACE_SLOW_SOURCE);
      queue_req(OP_QUERY, 0, 0, PACE_SLOW_SOURCE);
      queue_req(OP_FREE, NUM_BLOCKS - 1, 0, PACE_SLOW_SOURCE);
      queue_req(OP_FREE, NUM_BLOCKS - 1, 0, PACE_SLOW_SOURCE);
      queue_req(OP_ALLOC, 0, 0, PACE_SLOW_SOURCE);
      queue_req(OP_QUERY, 0, 1, PACE_SLOW_SOURCE);

      // churn with fewer allocations
      feed_random(PACE_SLOW_SOURCE, 500, 35);
      feed_random(PACE_STEADY, 550, 35);

      wait_quiet();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/bba_pkg.sv
hw/rtl/bba_channels_if.sv
hw/rtl/bba_bitmap.sv
hw/rtl/bitmap_block_allocator.sv
hw/rtl/bba_checker.sv
tb/sv/tb_top.sv
